// ===== hdl/ntb_pkg.sv =====
// Shared types, constants and the tanh table for the tanh neuron core.
package ntb_pkg;

    // Sizing of the neuron.
    localparam int MAX_FANOUT = 64;
    localparam int TANH_DEPTH = 256;
    localparam int FAN_AW     = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
    localparam int TANH_AW    = $clog2(TANH_DEPTH);
    localparam int TANH_SHIFT = 27 - TANH_AW;

    // Q3.12 unity.
    localparam int Q_ONE = 4096;

    // Port widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;

    // Register map: the register index is paddr[2].
    localparam logic REG_STEP_GAIN = 1'b0;
    localparam logic [14:0] STEP_GAIN_RESET = 15'd4096;

    // Result kinds.
    localparam logic KIND_OUTPUT = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    typedef enum logic [1:0] {
        ACT_FEED  = 2'd0,
        ACT_BACK  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_SET   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    // Weight memory write and read requests.
    typedef struct packed {
        logic                     we;
        logic [FAN_AW-1:0]        addr;
        logic signed [15:0]       data;
    } ram_wr_t;

    typedef struct packed {
        logic                     re;
        logic [FAN_AW-1:0]        addr;
    } ram_rd_t;

    typedef logic [12:0] tanh_table_t [TANH_DEPTH];

    localparam longint unsigned Q30_ONE  = 64'd1073741824;
    localparam longint unsigned Q30_EINV = 64'd395007542;

    // Restoring division, used only while the table is built.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = 64'd0;
        rem = 64'd0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds tanh(8*i/TANH_DEPTH) in Q3.12 from a Taylor series of e^-x in Q30.
    function automatic tanh_table_t build_tanh_table();
        tanh_table_t     tab;
        longint unsigned y;
        longint unsigned n;
        longint unsigned f;
        longint unsigned mag;
        longint unsigned t;
        longint unsigned j;
        longint          sum;
        int              k;
        int              i;
        for (i = 0; i < TANH_DEPTH; i++)
        begin
            y   = ((64'd16 * longint'(i)) << 30) / TANH_DEPTH;
            n   = y >> 30;
            f   = y & (Q30_ONE - 64'd1);
            mag = Q30_ONE;
            sum = longint'(Q30_ONE);
            for (k = 1; k <= 24; k++)
            begin
                mag = div_u64((mag * f) >> 30, 64'(k));
                if ((k & 1) != 0)
                begin
                    sum = sum - longint'(mag);
                end
                else
                begin
                    sum = sum + longint'(mag);
                end
            end
            t = (sum < 0) ? 64'd0 : longint'(sum);
            for (j = 0; j < n; j++)
            begin
                t = (t * Q30_EINV) >> 30;
            end
            if (t > Q30_ONE)
            begin
                t = Q30_ONE;
            end
            tab[i] = 13'(div_u64((Q30_ONE - t) * 64'd8192 + Q30_ONE + t,
                                 64'd2 * (Q30_ONE + t)));
        end
        return tab;
    endfunction

    localparam tanh_table_t TANH_TABLE = build_tanh_table();

endpackage

// ===== hdl/ntb_apb_regs.sv =====
// APB register block holding the learning rate.
module ntb_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ntb_pkg::CFG_AW-1:0]  paddr,
    input  logic [ntb_pkg::CFG_DW-1:0]  pwdata,
    output logic [ntb_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output logic [14:0]                 step_gain
);
    import ntb_pkg::*;

    logic [14:0] step_gain_reg;
    logic        wr_en;

    // A write completes in the access phase; the port never waits.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg <= STEP_GAIN_RESET;
        end
        else if (wr_en && (paddr[2] == REG_STEP_GAIN))
        begin
            step_gain_reg <= pwdata[14:0];
        end
    end

    // Read back; addresses with paddr[2] set read as zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_STEP_GAIN)
        begin
            prdata = CFG_DW'(step_gain_reg);
        end
    end

    assign step_gain = step_gain_reg;

endmodule

// ===== hdl/ntb_weight_ram.sv =====
// Outgoing weight memory with registered read and per-entry valid bits.
module ntb_weight_ram (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ntb_pkg::ram_wr_t     wr,
    input  ntb_pkg::ram_rd_t     rd,
    output logic signed [15:0]   rdata
);
    import ntb_pkg::*;

    logic signed [15:0]    mem_reg [MAX_FANOUT];
    logic [MAX_FANOUT-1:0] valid_reg;
    logic signed [15:0]    rdata_reg;
    logic                  rvalid_reg;

    // Storage array and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd.re)
        begin
            rdata_reg <= mem_reg[rd.addr];
        end
    end

    // Valid bits make never-written entries read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.re)
            begin
                rvalid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 16'sd0;

endmodule

// ===== hdl/ntb_tanh_lookup.sv =====
// Tanh of a Q7.24 net input, looked up in the Q3.12 table.
module ntb_tanh_lookup (
    input  logic signed [31:0] net,
    output logic signed [13:0] th
);
    import ntb_pkg::*;

    logic [31:0] mag;
    logic [31:0] idx_full;
    logic        in_range;
    logic [12:0] th_mag;

    // The magnitude of the most negative value still fits as unsigned.
    assign mag      = net[31] ? (~net + 32'd1) : net;
    assign idx_full = mag >> TANH_SHIFT;
    assign in_range = idx_full < 32'(TANH_DEPTH);

    // Beyond the table the curve is flat at one.
    assign th_mag = in_range ? TANH_TABLE[idx_full[TANH_AW-1:0]] : 13'(Q_ONE);
    assign th     = net[31] ? -$signed({1'b0, th_mag}) : $signed({1'b0, th_mag});

endmodule

// ===== hdl/neuron_tanh_backprop_unit_core.sv =====
// Tanh neuron core: forward sums, tanh output, error back-propagation, weight update.
// Feed and back terms are accepted in idle (memory read or product), then add and write back in execute.
// A last term then passes through finish, which forms the output or error result.
// Weight writes and output set-ups complete at accept; a last term waits while the result is held.
// Reset clears the pass, sum, tanh and output and sets the derivative to one; weight valid bits read zero.
module neuron_tanh_backprop_unit_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // term_weight [15:0], term_value [31:16], target_index [37:32], zero pad
    input  logic [ntb_pkg::S_TDATA_W-1:0]  s_tdata,
    // action [1:0], skip_term [2]
    input  logic [ntb_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_value [15:0]
    output logic [ntb_pkg::M_TDATA_W-1:0]  m_tdata,
    // result_kind [0]
    output logic [ntb_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ntb_pkg::CFG_AW-1:0]     paddr,
    input  logic [ntb_pkg::CFG_DW-1:0]     pwdata,
    output logic [ntb_pkg::CFG_DW-1:0]     prdata,
    output logic                           pready
);
    import ntb_pkg::*;

    // Control state.
    state_t             state_reg;
    state_t             state_next;
    logic               pass_open_reg;
    logic signed [31:0] sum_reg;
    logic signed [13:0] th_reg;
    logic [12:0]        d_reg;
    logic [12:0]        d_next;
    logic signed [15:0] own_output_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               out_load;

    // Request held between accept and execute.
    logic               is_back_reg;
    logic               last_reg;
    logic               back_active_reg;
    logic signed [15:0] v_reg;
    logic signed [31:0] prod_reg;
    logic [FAN_AW-1:0]  addr_reg;
    logic               m_kind_reg;
    logic signed [15:0] m_value_reg;

    // Incoming request fields.
    logic               in_acc;
    action_t            in_action;
    logic               in_skip;
    logic signed [15:0] w_in;
    logic signed [15:0] v_in;
    logic [5:0]         in_index;
    logic               in_range;
    logic [FAN_AW-1:0]  in_addr;
    logic signed [15:0] mult_b;
    logic signed [31:0] prod_next;

    // Execute datapath.
    logic [14:0]        step_gain;
    logic signed [15:0] lr_s;
    logic signed [15:0] w_old;
    logic signed [31:0] sum_base;
    logic signed [31:0] back_prod;
    logic signed [31:0] addend;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_new;
    logic signed [47:0] scaled;
    logic signed [47:0] scaled_r;
    logic signed [23:0] delta;
    logic signed [24:0] w_wide;
    logic signed [15:0] w_new;

    // Finish datapath.
    logic signed [13:0] th_fin;
    logic signed [13:0] d_s;
    logic signed [45:0] err_prod;
    logic signed [45:0] err_r;
    logic signed [21:0] err_q;
    logic signed [15:0] err_val;
    logic signed [15:0] fin_value;
    logic signed [27:0] th_sq;
    logic signed [27:0] sq_r;

    ram_wr_t            ram_wr;
    ram_rd_t            ram_rd;

    ntb_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .step_gain (step_gain)
    );

    ntb_weight_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (w_old)
    );

    ntb_tanh_lookup u_tanh (
        .net (sum_reg),
        .th  (th_fin)
    );

    // Unpack the request.
    assign in_action = action_t'(s_tuser[1:0]);
    assign in_skip   = s_tuser[2];
    assign w_in      = $signed(s_tdata[15:0]);
    assign v_in      = $signed(s_tdata[31:16]);
    assign in_index  = s_tdata[37:32];
    assign in_range  = {26'd0, in_index} < 32'(MAX_FANOUT);
    assign in_addr   = FAN_AW'(in_index);
    assign in_acc    = s_tvalid && s_tready;

    // One shared multiplier at accept: weight times input for feed, error times output for back.
    assign mult_b    = (in_action == ACT_FEED) ? w_in : own_output_reg;
    assign prod_next = v_in * mult_b;

    // State machine.
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && (in_action inside {ACT_FEED, ACT_BACK}))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Running sum update with signed 32-bit saturation.
    assign sum_base  = pass_open_reg ? sum_reg : 32'sd0;
    assign back_prod = v_reg * w_old;
    assign addend    = is_back_reg ? (back_active_reg ? back_prod : 32'sd0) : prod_reg;
    assign sum_wide  = {sum_base[31], sum_base} + {addend[31], addend};

    always_comb
    begin
        if (sum_wide[32] != sum_wide[31])
        begin
            sum_new = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_new = sum_wide[31:0];
        end
    end

    // Weight update: rate times (error times own output), rounded half up.
    assign lr_s     = $signed({1'b0, step_gain});
    assign scaled   = lr_s * prod_reg;
    assign scaled_r = scaled + 48'sd8388608;
    assign delta    = scaled_r[47:24];
    assign w_wide   = {{9{w_old[15]}}, w_old} + {delta[23], delta};

    always_comb
    begin
        if (w_wide > 25'sd32767)
        begin
            w_new = 16'sh7FFF;
        end
        else if (w_wide < -25'sd32768)
        begin
            w_new = 16'sh8000;
        end
        else
        begin
            w_new = w_wide[15:0];
        end
    end

    // Memory requests: reads at accept, write-back in execute, direct writes at accept.
    always_comb
    begin
        ram_rd.re   = in_acc && (in_action == ACT_BACK) && in_range;
        ram_rd.addr = in_addr;
        if (state_reg == S_EXEC)
        begin
            ram_wr.we   = back_active_reg;
            ram_wr.addr = addr_reg;
            ram_wr.data = w_new;
        end
        else
        begin
            ram_wr.we   = in_acc && (in_action == ACT_WRITE) && in_range;
            ram_wr.addr = in_addr;
            ram_wr.data = w_in;
        end
    end

    // Derivative 1 - tanh(net)^2, kept up to date behind the stored tanh.
    assign th_sq  = th_reg * th_reg;
    assign sq_r   = th_sq + 28'sd2048;
    assign d_next = 13'(Q_ONE) - sq_r[24:12];

    // Error = sum times derivative, rounded half up and saturated.
    assign d_s      = $signed({1'b0, d_reg});
    assign err_prod = sum_reg * d_s;
    assign err_r    = err_prod + 46'sd8388608;
    assign err_q    = err_r[45:24];

    always_comb
    begin
        if (err_q > 22'sd32767)
        begin
            err_val = 16'sh7FFF;
        end
        else if (err_q < -22'sd32768)
        begin
            err_val = 16'sh8000;
        end
        else
        begin
            err_val = err_q[15:0];
        end
    end

    assign fin_value = is_back_reg ? err_val : {{2{th_fin[13]}}, th_fin};

    // Result register handshake.
    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and neuron state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_open_reg  <= 1'b0;
            sum_reg        <= 32'sd0;
            th_reg         <= 14'sd0;
            d_reg          <= 13'(Q_ONE);
            own_output_reg <= 16'sd0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            d_reg       <= d_next;
            m_valid_reg <= m_valid_next;
            if (in_acc && (in_action == ACT_SET))
            begin
                own_output_reg <= v_in;
            end
            if (state_reg == S_EXEC)
            begin
                sum_reg       <= sum_new;
                pass_open_reg <= !last_reg;
            end
            if (out_load && !is_back_reg)
            begin
                th_reg         <= th_fin;
                own_output_reg <= {{2{th_fin[13]}}, th_fin};
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            is_back_reg     <= (in_action == ACT_BACK);
            last_reg        <= s_tlast;
            back_active_reg <= (in_action == ACT_BACK) && !in_skip && in_range;
            v_reg           <= v_in;
            prod_reg        <= prod_next;
            addr_reg        <= in_addr;
        end
        if (out_load)
        begin
            m_kind_reg  <= is_back_reg ? KIND_ERROR : KIND_OUTPUT;
            m_value_reg <= fin_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;

`ifndef SYNTHESIS
    a_term_executes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_action == ACT_FEED || in_action == ACT_BACK)) |=> state_reg == S_EXEC)
        else $error("accepted term did not enter execute");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr.we && ram_rd.re))
        else $error("weight memory read and write in the same cycle");

    a_pass_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> !pass_open_reg)
        else $error("pass still open while forming a result");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && (!m_valid_reg || m_tready)) |=>
        (m_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded on leaving finish");
`endif

endmodule

// ===== test/neuron_tanh_backprop_unit_core_test.sv =====
// Self-checking testbench for the tanh neuron core: a predictor, random requests and stalls, and a result check.
module neuron_tanh_backprop_unit_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ntb_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_TERMS   = 310;
    localparam int NUM_PHASES    = 6;
    localparam logic [CFG_AW-1:0] RATE_ADDR = CFG_AW'({REG_STEP_GAIN, 2'b00});

    // One request to the neuron, as the fields of the input bus.
    typedef struct {
        action_t            act;
        logic signed [15:0] weight;
        logic signed [15:0] value;
        logic [5:0]         slot;
        logic               skip;
        logic               last;
    } neuron_term_t;

    // One result of the neuron: an output after a feed pass or an error after a back pass.
    typedef struct {
        logic               kind;
        logic signed [15:0] value;
    } neuron_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [CFG_DW-1:0]     pwdata;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    // Requests waiting to be offered, and results the neuron still owes.
    neuron_term_t   pending_terms[$];
    neuron_result_t due_results[$];

    // Predictor state.
    int                 tanh_lut [TANH_DEPTH];
    logic signed [15:0] weight_copy [MAX_FANOUT];
    logic signed [31:0] net_copy;
    logic signed [31:0] sum_copy;
    logic signed [15:0] output_copy;
    logic signed [15:0] error_copy;
    logic               pass_live;
    logic [14:0]        rate_copy;

    // Handshake and pacing bookkeeping.
    bit offering;
    bit term_taken;
    bit result_taken;
    bit bursty;
    bit calm;
    bit hold_request;
    int mode_left;
    int send_gap;
    int stall_left;
    int hold_left;
    int quiet_cycles;
    int failures;

    always #5 clk = ~clk;

    neuron_tanh_backprop_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Fills the tanh table from a Taylor series of e^-x in Q30, scaled by e^-1 per whole unit.
    task automatic fill_tanh_lut();
        longint unsigned unity;
        longint unsigned e_inv;
        longint unsigned arg;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned term;
        longint unsigned decay;
        longint          series;
        unity = 64'd1073741824;
        e_inv = 64'd395007542;
        for (int i = 0; i < TANH_DEPTH; i++)
        begin
            arg    = (longint'(16 * i) << 30) / TANH_DEPTH;
            whole  = arg >> 30;
            frac   = arg & (unity - 1);
            term   = unity;
            series = longint'(unity);
            for (int k = 1; k <= 24; k++)
            begin
                term = ((term * frac) >> 30) / longint'(k);
                series = (k % 2 == 1) ? series - longint'(term) : series + longint'(term);
            end
            decay = (series < 0) ? 0 : longint'(series);
            for (longint unsigned j = 0; j < whole; j++)
            begin
                decay = (decay * e_inv) >> 30;
            end
            if (decay > unity)
            begin
                decay = unity;
            end
            tanh_lut[i] = int'(((unity - decay) * 8192 + unity + decay) / (2 * (unity + decay)));
        end
    endtask

    // tanh of a Q7.24 net input, in Q3.12, from the table.
    function automatic longint tanh_of(logic signed [31:0] net);
        longint mag;
        longint idx;
        longint th;
        mag = (net < 0) ? -longint'(net) : longint'(net);
        idx = (mag * TANH_DEPTH) >>> 27;
        th  = (idx >= TANH_DEPTH) ? Q_ONE : tanh_lut[idx];
        return (net < 0) ? -th : th;
    endfunction

    // Advances the neuron by one accepted request and records any result it owes.
    task automatic advance_neuron(neuron_term_t t);
        logic signed [15:0] old_w;
        longint             delta;
        longint             th;
        longint             slope;
        neuron_result_t     owed;
        case (t.act)
            ACT_WRITE:
            begin
                weight_copy[t.slot] = t.weight;
            end
            ACT_SET:
            begin
                output_copy = t.value;
            end
            default:
            begin
                if (!pass_live)
                begin
                    sum_copy = '0;
                end
                pass_live = 1'b1;
                if (t.act == ACT_FEED)
                begin
                    sum_copy = sat32(longint'(sum_copy) + longint'(t.weight) * longint'(t.value));
                end
                else if (!t.skip)
                begin
                    old_w    = weight_copy[t.slot];
                    sum_copy = sat32(longint'(sum_copy) + longint'(t.value) * longint'(old_w));
                    delta    = (longint'(rate_copy) * (longint'(t.value) * longint'(output_copy))
                                + (longint'(1) <<< 23)) >>> 24;
                    weight_copy[t.slot] = sat16(longint'(old_w) + delta);
                end
                if (t.last)
                begin
                    pass_live = 1'b0;
                    if (t.act == ACT_FEED)
                    begin
                        net_copy    = sum_copy;
                        output_copy = sat16(tanh_of(net_copy));
                        owed.kind   = KIND_OUTPUT;
                        owed.value  = output_copy;
                    end
                    else
                    begin
                        th         = tanh_of(net_copy);
                        slope      = Q_ONE - ((th * th + 2048) >>> 12);
                        error_copy = sat16((longint'(sum_copy) * slope + (longint'(1) <<< 23)) >>> 24);
                        owed.kind  = KIND_ERROR;
                        owed.value = error_copy;
                    end
                    due_results.insert(due_results.size(), owed);
                    sum_copy = '0;
                end
            end
        endcase
    endtask

    task automatic queue_term(action_t a, int w, int v, int slot, bit skip, bit last);
        neuron_term_t t;
        t.act    = a;
        t.weight = w[15:0];
        t.value  = v[15:0];
        t.slot   = slot[5:0];
        t.skip   = skip;
        t.last   = last;
        pending_terms.insert(pending_terms.size(), t);
    endtask

    // A Q3.12 value: often an extreme, zero or a tiny value, often within unity, otherwise anything.
    function automatic int pick_q12();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return ($urandom_range(0, 1) == 1) ? 1 : -1;
            4, 5: return int'($urandom_range(0, 8192)) - 4096;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Mostly training steps (a feed pass then a back pass), with weight writes,
    // output set-ups and unstructured requests mixed in.
    task automatic queue_random_phase(int count);
        int queued;
        int n;
        queued = 0;
        while (queued < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    queue_term(action_t'($urandom_range(0, 3)), pick_q12(), pick_q12(),
                               $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 1));
                    queued++;
                end
                1:
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                    begin
                        queue_term(ACT_WRITE, pick_q12(), pick_q12(), $urandom_range(0, 63),
                                   $urandom_range(0, 1), $urandom_range(0, 1));
                    end
                    queued += n;
                end
                2:
                begin
                    queue_term(ACT_SET, pick_q12(), pick_q12(), $urandom_range(0, 63),
                               $urandom_range(0, 1), $urandom_range(0, 1));
                    queued++;
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                    begin
                        queue_term(ACT_FEED, pick_q12(), pick_q12(), $urandom_range(0, 63),
                                   $urandom_range(0, 1), i == n - 1);
                    end
                    queued += n;
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                    begin
                        queue_term(ACT_BACK, pick_q12(), pick_q12(), $urandom_range(0, 63),
                                   $urandom_range(0, 7) == 0, i == n - 1);
                    end
                    queued += n;
                end
            endcase
        end
    endtask

    // Writes the learning rate over the register port and reads it back.
    task automatic write_step_gain(logic [14:0] rate);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = RATE_ADDR;
        pwdata  = CFG_DW'(rate);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rate_copy = rate;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== CFG_DW'(rate))
        begin
            $error("step_gain readback mismatch: expected %0d, actual %0d", rate, prdata);
            failures++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until every request is in and every result is out, then lets the core settle.
    task automatic settle_all();
        while (pending_terms.size() != 0 || offering || due_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Alternates stretches with idling bursts and stretches without.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            bursty    = !bursty;
            mode_left = $urandom_range(20, 150);
        end
        else
        begin
            mode_left--;
        end
    end

    // Request driver: offers the next pending request once the current one is taken.
    always @(negedge clk)
    begin
        neuron_term_t t;
        if (rst_n && (!offering || term_taken))
        begin
            if (send_gap > 0 || pending_terms.size() == 0)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                offering = 1'b0;
                s_tvalid <= 1'b0;
            end
            else
            begin
                t = pending_terms.pop_front();
                offering = 1'b1;
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, t.slot, t.value, t.weight};
                s_tuser  <= {t.skip, t.act};
                s_tlast  <= t.last;
                if (!calm && bursty && $urandom_range(0, 3) == 0)
                begin
                    send_gap = $urandom_range(1, 5);
                end
            end
        end
    end

    // Result receiver: short random stalls, and one long hold-off when asked for.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && bursty && $urandom_range(0, 4) == 0)
                begin
                    stall_left = $urandom_range(1, 5);
                end
            end
        end
    end

    // Monitor: predicts on each accepted request, checks each result, and watches for a hang.
    always @(posedge clk)
    begin
        neuron_term_t   t;
        neuron_result_t want;
        if (rst_n)
        begin
            term_taken   = s_tvalid && s_tready;
            result_taken = m_tvalid && m_tready;
            if (term_taken)
            begin
                t.act    = action_t'(s_tuser[1:0]);
                t.weight = s_tdata[15:0];
                t.value  = s_tdata[31:16];
                t.slot   = s_tdata[37:32];
                t.skip   = s_tuser[2];
                t.last   = s_tlast;
                advance_neuron(t);
            end
            if (result_taken)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, value %0d", m_tuser[0], $signed(m_tdata));
                    failures++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser[0] !== want.kind)
                    begin
                        $error("result_kind mismatch: expected %0d, actual %0d",
                               want.kind, m_tuser[0]);
                        failures++;
                    end
                    if ($signed(m_tdata) !== want.value)
                    begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want.value, $signed(m_tdata));
                        failures++;
                    end
                end
            end
            if (term_taken || result_taken || (psel && penable && pready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Sequence: reset, directed requests, then random phases under several learning rates.
    initial
    begin
        logic [14:0] rate;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        bursty       = 1'b1;
        mode_left    = 40;
        failures     = 0;
        fill_tanh_lut();
        for (int i = 0; i < MAX_FANOUT; i++)
        begin
            weight_copy[i] = '0;
        end
        net_copy    = '0;
        sum_copy    = '0;
        output_copy = '0;
        error_copy  = '0;
        pass_live   = 1'b0;
        rate_copy   = STEP_GAIN_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset learning rate.
        queue_term(ACT_WRITE, 32767, 0, 0, 1'b0, 1'b0);
        queue_term(ACT_WRITE, -32768, 0, 63, 1'b1, 1'b1);
        queue_term(ACT_SET, 0, -32768, 0, 1'b0, 1'b1);
        // The sum saturates high; skip is ignored on a feed term.
        queue_term(ACT_FEED, -32768, -32768, 0, 1'b0, 1'b0);
        queue_term(ACT_FEED, -32768, -32768, 0, 1'b1, 1'b0);
        queue_term(ACT_FEED, -32768, -32768, 0, 1'b0, 1'b1);
        // The sum saturates low.
        queue_term(ACT_FEED, 32767, -32768, 0, 1'b0, 1'b0);
        queue_term(ACT_FEED, 32767, -32768, 0, 1'b0, 1'b0);
        queue_term(ACT_FEED, 32767, -32768, 63, 1'b0, 1'b1);
        // Back pass with a write and a set mid-pass, ending on a skipped term.
        queue_term(ACT_BACK, 0, 32767, 0, 1'b0, 1'b0);
        queue_term(ACT_BACK, 0, -32768, 63, 1'b0, 1'b0);
        queue_term(ACT_WRITE, 1000, 0, 5, 1'b0, 1'b1);
        queue_term(ACT_SET, 0, 2048, 5, 1'b0, 1'b0);
        queue_term(ACT_BACK, 0, -32768, 5, 1'b1, 1'b1);
        // Moderate net input, then a pass that mixes feed and back terms.
        queue_term(ACT_FEED, 4096, 2048, 0, 1'b0, 1'b1);
        queue_term(ACT_BACK, 0, 32767, 5, 1'b0, 1'b0);
        queue_term(ACT_FEED, 100, -300, 0, 1'b0, 1'b0);
        queue_term(ACT_BACK, 0, -5000, 63, 1'b0, 1'b1);
        // Zero and tiny negative net inputs, and a pass of one skipped back term.
        queue_term(ACT_FEED, 0, 0, 0, 1'b0, 1'b1);
        queue_term(ACT_BACK, 0, 12345, 62, 1'b1, 1'b1);
        queue_term(ACT_FEED, -1, 1, 0, 1'b0, 1'b1);
        // Two updates of one weight drive it into saturation.
        queue_term(ACT_SET, 0, 32767, 0, 1'b0, 1'b0);
        queue_term(ACT_BACK, 0, 32767, 1, 1'b0, 1'b0);
        queue_term(ACT_BACK, 0, 32767, 1, 1'b0, 1'b1);
        settle_all();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: rate = 15'd0;
                1: rate = 15'd32767;
                2: rate = 15'd1;
                5: rate = STEP_GAIN_RESET;
                default: rate = 15'($urandom_range(0, 32767));
            endcase
            write_step_gain(rate);
            if (phase == 1)
            begin
                hold_request = 1'b1;
            end
            if (phase == NUM_PHASES - 1)
            begin
                calm = 1'b1;
            end
            queue_random_phase(PHASE_TERMS);
            settle_all();
        end

        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
